/* rtl/multi_plane_bit_flag_store_assert.svh */
// Assertion macros shared by the flag store.
`ifndef MULTI_PLANE_BIT_FLAG_STORE_ASSERT_SVH
`define MULTI_PLANE_BIT_FLAG_STORE_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define MPBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define MPBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mpbf_pkg.sv */
package mpbf_pkg;

    localparam int unsigned MAX_ITEMS       = 1024;
    localparam int unsigned PLANES          = 8;
    localparam int unsigned WORD_BITS       = 32;
    localparam int unsigned BIT_IDX_W       = $clog2(WORD_BITS);
    localparam int unsigned WORDS_PER_PLANE = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned STORE_WORDS     = PLANES * WORDS_PER_PLANE;
    localparam int unsigned WIDX_W          = $clog2(WORDS_PER_PLANE);
    localparam int unsigned PIDX_W          = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int unsigned ADDR_W          = $clog2(STORE_WORDS);

    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned ITEM_W  = 10;
    localparam int unsigned PLANE_W = 3;
    localparam int unsigned PADDR_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        F_READ     = 3'd0,
        F_SET      = 3'd1,
        F_CLEAR    = 3'd2,
        F_TEST_SET = 3'd3,
        F_TEST_CLR = 3'd4,
        F_FILL     = 3'd5,
        F_FILL_ALL = 3'd6,
        F_NONE     = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FILL
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ITEM_W-1:0]  item;
        logic [PLANE_W-1:0] plane;
        logic               fill_value;
    } t_req;

    typedef struct packed {
        logic bit_res;
        logic error;
    } t_res;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } t_ram_req;

endpackage

/* rtl/mpbf_ram.sv */
module mpbf_ram (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mpbf_pkg::t_ram_req                     i_req,
    output logic [mpbf_pkg::WORD_BITS-1:0]         o_rdata
);
    import mpbf_pkg::*;

    logic [WORD_BITS-1:0]   r_mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_valid;
    logic [WORD_BITS-1:0]   r_rdata;
    logic                   r_rvalid;

    // Words never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata  <= r_mem[i_req.raddr];
        r_rvalid <= r_valid[i_req.raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* rtl/mpbf_ctrl.sv */
module mpbf_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  mpbf_pkg::t_req                     i_req,
    input  logic [mpbf_pkg::PLANE_W-1:0]       i_planes_in_use,
    input  logic [mpbf_pkg::WORD_BITS-1:0]     i_rdata,
    output logic                               o_busy,
    output logic                               o_done,
    output mpbf_pkg::t_res                     o_res,
    output mpbf_pkg::t_ram_req                 o_ram
);
    import mpbf_pkg::*;

    t_state               r_state, n_state;
    t_func                r_func, n_func;
    logic [BIT_IDX_W-1:0] r_bitpos, n_bitpos;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [PIDX_W-1:0]    r_plane, n_plane;
    logic [PIDX_W-1:0]    r_top, n_top;
    logic [WIDX_W-1:0]    r_word, n_word;
    logic                 r_fill, n_fill;
    logic                 r_done, n_done;
    t_res                 r_res, n_res;

    t_func                req_func;
    logic                 accept;
    logic                 plane_err;
    logic                 item_err;
    logic                 req_err;
    logic [PIDX_W-1:0]    req_plane;
    logic [ADDR_W-1:0]    req_addr;
    logic [PIDX_W-1:0]    fill_top;
    logic [WORD_BITS-1:0] mask;
    logic                 old_bit;
    logic                 word_last;
    logic                 plane_last;

    assign req_func  = t_func'(i_req.func);
    assign accept    = i_start && (r_state == S_IDLE);
    assign req_plane = i_req.plane[PIDX_W-1:0];
    assign req_addr  = {req_plane, i_req.item[WIDX_W+BIT_IDX_W-1:BIT_IDX_W]};

    assign plane_err = (i_req.plane > i_planes_in_use) || (32'(i_req.plane) >= PLANES);
    assign item_err  = (32'(i_req.item) >= MAX_ITEMS);
    assign req_err   = (req_func == F_FILL) ? plane_err
                     : (req_func == F_FILL_ALL || req_func == F_NONE) ? 1'b0
                     : (plane_err || item_err);

    assign fill_top = (32'(i_planes_in_use) > PLANES - 1) ? PIDX_W'(PLANES - 1)
                                                          : PIDX_W'(i_planes_in_use);

    // The shared bit unit: one shifter builds the mask for the word in flight.
    assign mask       = WORD_BITS'(1) << r_bitpos;
    assign old_bit    = |(i_rdata & mask);
    assign word_last  = (r_word == WIDX_W'(WORDS_PER_PLANE - 1));
    assign plane_last = (r_plane == r_top);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !req_err) begin
                    if (req_func == F_FILL || req_func == F_FILL_ALL) begin
                        n_state = S_FILL;
                    end else if (req_func != F_NONE) begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_state = S_IDLE;
            end
            S_FILL: begin
                if (word_last && plane_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory request and result.
    always_comb begin
        n_func      = r_func;
        n_bitpos    = r_bitpos;
        n_addr      = r_addr;
        n_plane     = r_plane;
        n_top       = r_top;
        n_word      = r_word;
        n_fill      = r_fill;
        n_done      = 1'b0;
        n_res       = r_res;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_addr;
        o_ram.wdata = '0;
        o_ram.raddr = req_addr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = req_func;
                    n_bitpos = i_req.item[BIT_IDX_W-1:0];
                    n_addr   = req_addr;
                    n_fill   = i_req.fill_value;
                    n_word   = '0;
                    if (req_func == F_FILL_ALL) begin
                        n_plane = '0;
                        n_top   = fill_top;
                    end else begin
                        n_plane = req_plane;
                        n_top   = req_plane;
                    end
                    if (req_err || req_func == F_NONE) begin
                        n_done        = 1'b1;
                        n_res.bit_res = 1'b0;
                        n_res.error   = req_err;
                    end
                end
            end
            S_MOD: begin
                o_ram.waddr   = r_addr;
                n_done        = 1'b1;
                n_res.error   = 1'b0;
                n_res.bit_res = 1'b0;
                case (r_func)
                    F_READ: begin
                        n_res.bit_res = old_bit;
                    end
                    F_SET: begin
                        o_ram.we    = 1'b1;
                        o_ram.wdata = i_rdata | mask;
                    end
                    F_CLEAR: begin
                        o_ram.we    = 1'b1;
                        o_ram.wdata = i_rdata & ~mask;
                    end
                    F_TEST_SET: begin
                        o_ram.we      = 1'b1;
                        o_ram.wdata   = i_rdata | mask;
                        n_res.bit_res = old_bit;
                    end
                    F_TEST_CLR: begin
                        o_ram.we      = 1'b1;
                        o_ram.wdata   = i_rdata & ~mask;
                        n_res.bit_res = old_bit;
                    end
                    default: begin
                        o_ram.we = 1'b0;
                    end
                endcase
            end
            S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = {r_plane, r_word};
                o_ram.wdata = {WORD_BITS{r_fill}};
                n_word      = r_word + WIDX_W'(1);
                if (word_last) begin
                    if (plane_last) begin
                        n_done        = 1'b1;
                        n_res.bit_res = 1'b0;
                        n_res.error   = 1'b0;
                    end else begin
                        n_plane = r_plane + PIDX_W'(1);
                    end
                end
            end
            default: begin
                o_ram.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_bitpos <= n_bitpos;
        r_addr   <= n_addr;
        r_plane  <= n_plane;
        r_top    <= n_top;
        r_word   <= n_word;
        r_fill   <= n_fill;
        r_res    <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* rtl/multi_plane_bit_flag_store.sv */
// A bit operation reads its word on the accepting edge, writes the modified word back in S_MOD
// unless it is a read, and registers its result; no new request is taken while busy. A fill
// writes one word a cycle, 32 per plane, over the addressed plane, or over planes 0
// through planes_in_use for fill-all. Rejected requests and the undefined function answer
// back to back. The receiver cannot stall: o_done marks each result for one cycle.
// Synchronous active-low reset clears the controller, planes_in_use and the store's valid bits.
module multi_plane_bit_flag_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request channel
    input  logic                             start,
    output logic                             busy,
    input  mpbf_pkg::t_req                   i_req,
    // Result channel
    output logic                             o_done,
    output mpbf_pkg::t_res                   o_res,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mpbf_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mpbf_pkg::*;

    `include "multi_plane_bit_flag_store_assert.svh"

    // Register file: a single register, planes_in_use, at byte address zero. The register
    // index is the word address, so only bit 2 of paddr selects it; writes elsewhere are
    // completed on the bus and dropped.
    logic [PLANE_W-1:0]   r_planes_in_use;
    logic                 cfg_write;
    logic                 cfg_hit;
    t_ram_req             ram_req;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 err_beat;
    logic                 fill_all_beat;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes_in_use <= '0;
        end else if (cfg_write && cfg_hit) begin
            r_planes_in_use <= pwdata[PLANE_W-1:0];
        end
    end

    assign prdata = cfg_hit ? 32'(r_planes_in_use) : 32'd0;

    // The controller owns the sequencer and the shared bit unit. It reads the addressed
    // word on the accepting edge, then, but for a read, writes the modified word back in the next cycle.
    // Fills reuse the same write path with a word counter walking each plane.
    mpbf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_req           (i_req),
        .i_planes_in_use (r_planes_in_use),
        .i_rdata         (ram_rdata),
        .o_busy          (busy),
        .o_done          (o_done),
        .o_res           (o_res),
        .o_ram           (ram_req)
    );

    // Flag store: one word per plane and word index, with a valid bit per word so
    // that the whole store reads as zero right after reset without a clearing pass.
    mpbf_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign err_beat      = o_done && o_res.error;
    assign fill_all_beat = start && !busy && (i_req.func == F_FILL_ALL);

    // A rejected request never reports a bit.
    `MPBF_ASSERT_NOW(a_err_no_bit, i_clk, i_rst_n, err_beat, !o_res.bit_res, "bit on error")

    // Every multi-cycle operation ends with exactly its result beat.
    `MPBF_ASSERT_NOW(a_busy_end_done, i_clk, i_rst_n, $fell(busy), o_done, "no end beat")

    // A fill-all request always walks the store.
    `MPBF_ASSERT_NEXT(a_fill_all_busy, i_clk, i_rst_n, fill_all_beat, busy, "fill-all idle")

endmodule
